// ===== design/mmt_pkg.sv =====
// Shared sizes, codes and types for the A times B-transposed block.
package mmt_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_DEPTH = 128;

  localparam int KD_W   = $clog2(MAX_DEPTH);
  localparam int KC_W   = KD_W + 1;
  localparam int ADDR_W = $clog2(MAX_ROWS * MAX_DEPTH);

  localparam int OPND_W = 16;
  localparam int MUL_W  = 2 * OPND_W;
  localparam int ACC_W  = 40;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_B_ROWS = 2'd1;
  localparam logic [1:0] REG_DEPTH  = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic clear;
    logic en;
    logic last;
  } mac_ctl_t;

  // element (r, c) sits at r * MAX_DEPTH + c
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] c);
    elem_addr = ADDR_W'(r * ADDR_W'(MAX_DEPTH) + c);
  endfunction

endpackage

// ===== design/mmt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mmt_mac.sv =====
// Shared multiply-accumulate unit: registered product, then 40-bit accumulator.
module mmt_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  mmt_pkg::mac_ctl_t                 ctl,
  input  logic signed [mmt_pkg::OPND_W-1:0] a,
  input  logic signed [mmt_pkg::OPND_W-1:0] b,
  output logic signed [mmt_pkg::ACC_W-1:0]  acc,
  output logic                              done
);

  logic signed [mmt_pkg::MUL_W-1:0] prod;
  logic                             prod_valid;
  logic                             prod_last;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
    end else begin
      prod_valid <= ctl.en;
      prod_last  <= ctl.en & ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_valid & prod_last;
    end
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + mmt_pkg::ACC_W'(prod);
    end
  end

endmodule

// ===== design/matrix_mul_transposed.sv =====
// Top level: operand stores, query sequencer and result register for C = A * B^T.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low. func selects
//   load A, load B or query. A load writes value at (row, col) and
//   busy stays low, so loads can go back to back; out-of-range loads are dropped.
//   A query for (row, col) = (i, j) walks k = 0 .. min(depth, 128)-1 through the shared
//   multiply-accumulate unit, one product per cycle, reading row i of A and
//   row j of B from their RAMs. busy is high for the whole walk.
//   The done beat follows the walk through the RAM read, multiply and
//   accumulate stages and the result register.
//   The next item is taken only once busy drops after a query; loads and
//   early-done queries leave busy low.
//   A query with a row out of range, or with depth zero, gives its done beat in
//   the next cycle (status error and product 0, or status ok and product 0).
//   done is high for one cycle with product and status; the receiver cannot
//   stall, so the beat is simply presented once.
//   Config writes (cfg_wen, cfg_index, cfg_data) are taken in any cycle and
//   should only be issued while idle. Reset sets a_rows = b_rows = 32 and
//   depth = 128 and returns the sequencer to idle; RAM contents are not cleared.
module matrix_mul_transposed (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [4:0]         row,
  input  logic [6:0]         col,
  input  logic signed [15:0] value,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               done,
  output logic signed [39:0] product,
  output logic               status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [5:0] a_rows;
  logic [5:0] b_rows;
  logic [7:0] depth;

  logic [mmt_pkg::KC_W-1:0] kd_eff;
  logic [mmt_pkg::KC_W-1:0] kd;
  logic [mmt_pkg::KD_W-1:0] k;
  logic [4:0]               qa_row;
  logic [6:0]               qb_row;

  logic accept;
  logic load_ok_a;
  logic load_ok_b;
  logic query_err;
  logic last_issue;
  logic issue_valid;
  logic issue_last;

  logic                             we_a;
  logic                             we_b;
  logic [mmt_pkg::ADDR_W-1:0]       waddr;
  logic [mmt_pkg::ADDR_W-1:0]       raddr_a;
  logic [mmt_pkg::ADDR_W-1:0]       raddr_b;
  logic [mmt_pkg::OPND_W-1:0]       rdata_a;
  logic [mmt_pkg::OPND_W-1:0]       rdata_b;
  mmt_pkg::mac_ctl_t                mac_ctl;
  logic signed [mmt_pkg::ACC_W-1:0] mac_acc;
  logic                             mac_done;

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  assign kd_eff = (int'(depth) > mmt_pkg::MAX_DEPTH) ?
                  mmt_pkg::KC_W'(mmt_pkg::MAX_DEPTH) : mmt_pkg::KC_W'(depth);

  assign load_ok_a = (int'(row) < int'(a_rows)) && (int'(row) < mmt_pkg::MAX_ROWS) &&
                     (int'(col) < int'(kd_eff));
  assign load_ok_b = (int'(row) < int'(b_rows)) && (int'(row) < mmt_pkg::MAX_ROWS) &&
                     (int'(col) < int'(kd_eff));
  assign query_err = (int'(row) >= int'(a_rows)) || (int'(row) >= mmt_pkg::MAX_ROWS) ||
                     (int'(col) >= int'(b_rows)) || (int'(col) >= mmt_pkg::MAX_ROWS);

  assign we_a  = accept && (func == mmt_pkg::FUNC_LOAD_A) && load_ok_a;
  assign we_b  = accept && (func == mmt_pkg::FUNC_LOAD_B) && load_ok_b;
  assign waddr = mmt_pkg::elem_addr(mmt_pkg::ADDR_W'(row), mmt_pkg::ADDR_W'(col));

  assign raddr_a = mmt_pkg::elem_addr(mmt_pkg::ADDR_W'(qa_row), mmt_pkg::ADDR_W'(k));
  assign raddr_b = mmt_pkg::elem_addr(mmt_pkg::ADDR_W'(qb_row), mmt_pkg::ADDR_W'(k));

  assign last_issue = (mmt_pkg::KC_W'(k) == kd - mmt_pkg::KC_W'(1));

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= 6'd32;
      b_rows <= 6'd32;
      depth  <= 8'd128;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        mmt_pkg::REG_A_ROWS: a_rows <= cfg_data[5:0];
        mmt_pkg::REG_B_ROWS: b_rows <= cfg_data[5:0];
        mmt_pkg::REG_DEPTH:  depth  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && (func == mmt_pkg::FUNC_QUERY) && !query_err &&
            (kd_eff != '0)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (last_issue) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (mac_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      issue_valid <= 1'b0;
      issue_last  <= 1'b0;
    end else begin
      state       <= state_next;
      issue_valid <= (state == S_RUN);
      issue_last  <= (state == S_RUN) && last_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      k      <= '0;
      kd     <= kd_eff;
      qa_row <= row;
      qb_row <= col;
    end else if (state == S_RUN) begin
      k <= k + mmt_pkg::KD_W'(1);
    end
  end

  assign mac_ctl.clear = accept && (func == mmt_pkg::FUNC_QUERY);
  assign mac_ctl.en    = issue_valid;
  assign mac_ctl.last  = issue_last;

  mmt_ram #(
    .WIDTH (mmt_pkg::OPND_W),
    .DEPTH (mmt_pkg::MAX_ROWS * mmt_pkg::MAX_DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mmt_ram #(
    .WIDTH (mmt_pkg::OPND_W),
    .DEPTH (mmt_pkg::MAX_ROWS * mmt_pkg::MAX_DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  mmt_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    ($signed(rdata_a)),
    .b    ($signed(rdata_b)),
    .acc  (mac_acc),
    .done (mac_done)
  );

  // result beat: early for error or empty depth, else when the MAC finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (func == mmt_pkg::FUNC_QUERY) &&
               (query_err || (kd_eff == '0))) ||
              ((state == S_WAIT) && mac_done);
    end
    if (accept && (func == mmt_pkg::FUNC_QUERY) && query_err) begin
      product <= '0;
      status  <= mmt_pkg::STATUS_ERR;
    end else if (accept && (func == mmt_pkg::FUNC_QUERY) && (kd_eff == '0)) begin
      product <= '0;
      status  <= mmt_pkg::STATUS_OK;
    end else if ((state == S_WAIT) && mac_done) begin
      product <= mac_acc;
      status  <= mmt_pkg::STATUS_OK;
    end
  end

endmodule

// ===== verif/tb_matrix_mul_transposed.sv =====
`timescale 1ns / 100ps
// Self-checking bench for matrix_mul_transposed: operand loads, dot-product queries, register sweeps.
module tb_matrix_mul_transposed;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int STORE_SIZE    = mmt_pkg::MAX_ROWS * mmt_pkg::MAX_DEPTH;
  localparam int SETTLE_CYCLES = mmt_pkg::MAX_DEPTH + 8;

  typedef struct {
    logic [1:0]         func;
    logic [4:0]         row;
    logic [6:0]         col;
    logic signed [15:0] value;
  } mmt_beat_t;

  typedef struct {
    logic signed [39:0] product;
    logic               status;
  } dot_result_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic               busy;
  logic [1:0]         func      = mmt_pkg::FUNC_LOAD_A;
  logic [4:0]         row       = '0;
  logic [6:0]         col       = '0;
  logic signed [15:0] value     = '0;
  logic               cfg_wen   = 1'b0;
  logic [1:0]         cfg_index = mmt_pkg::REG_A_ROWS;
  logic [7:0]         cfg_data  = '0;
  logic               done;
  logic signed [39:0] product;
  logic               status;

  matrix_mul_transposed dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mmt_beat_t   beats_to_send[$];
  dot_result_t expected_products[$];
  int unsigned beats_queued, beats_taken, useful_beats;
  int unsigned idle_pct = 28;
  logic        took_beat = 1'b0;
  int          fails;
  int unsigned n_loads, n_queries, n_query_errs, n_dropped, n_settings;

  // predictor state: register copies and both operand stores
  logic [5:0]         cfg_a_rows = 6'd32;
  logic [5:0]         cfg_b_rows = 6'd32;
  logic [7:0]         cfg_depth  = 8'd128;
  logic signed [15:0] a_elems [STORE_SIZE];
  logic signed [15:0] b_elems [STORE_SIZE];

  // stimulus-side view: which elements will have been written once the queue drains
  int gen_ar, gen_br, gen_kd;
  bit a_loaded [STORE_SIZE];
  bit b_loaded [STORE_SIZE];

  function automatic int clamp_to_max(input int v, input int lim);
    return (v > lim) ? lim : v;
  endfunction

  task automatic compute_dot_beat(input mmt_beat_t b);
    int          ar, br, kd;
    longint      acc;
    dot_result_t r;
    ar = clamp_to_max(int'(cfg_a_rows), mmt_pkg::MAX_ROWS);
    br = clamp_to_max(int'(cfg_b_rows), mmt_pkg::MAX_ROWS);
    kd = clamp_to_max(int'(cfg_depth), mmt_pkg::MAX_DEPTH);
    case (b.func)
      mmt_pkg::FUNC_LOAD_A: begin
        if (b.row < ar && b.col < kd) begin
          a_elems[b.row * mmt_pkg::MAX_DEPTH + b.col] = b.value;
          n_loads++;
        end else begin
          n_dropped++;
        end
      end
      mmt_pkg::FUNC_LOAD_B: begin
        if (b.row < br && b.col < kd) begin
          b_elems[b.row * mmt_pkg::MAX_DEPTH + b.col] = b.value;
          n_loads++;
        end else begin
          n_dropped++;
        end
      end
      mmt_pkg::FUNC_QUERY: begin
        n_queries++;
        if (b.row >= ar || b.col >= br) begin
          r.product = '0;
          r.status  = mmt_pkg::STATUS_ERR;
          n_query_errs++;
        end else begin
          acc = 0;
          for (int k = 0; k < kd; k++)
            acc += longint'(a_elems[b.row * mmt_pkg::MAX_DEPTH + k]) *
                   longint'(b_elems[b.col * mmt_pkg::MAX_DEPTH + k]);
          r.product = acc[39:0];
          r.status  = mmt_pkg::STATUS_OK;
        end
        expected_products.push_back(r);
      end
      default: n_dropped++;
    endcase
  endtask

  // driver: a beat stays on the ports until it is taken
  always @(negedge clk) begin : drive_beats
    mmt_beat_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_beat) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = beats_to_send.pop_front();
        start <= 1'b1;
        func  <= nxt.func;
        row   <= nxt.row;
        col   <= nxt.col;
        value <= nxt.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch_ports
    dot_result_t want;
    mmt_beat_t   got;
    took_beat <= !rst && start && !busy;
    if (rst) begin
      cfg_a_rows = 6'd32;
      cfg_b_rows = 6'd32;
      cfg_depth  = 8'd128;
    end else begin
      if (done) begin
        if (expected_products.size() == 0) begin
          $error("unexpected result beat: product %0d status %0d", product, status);
          fails++;
        end else begin
          want = expected_products.pop_front();
          if (product !== want.product) begin
            $error("product: expected %0d, got %0d", want.product, product);
            fails++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          mmt_pkg::REG_A_ROWS: cfg_a_rows = cfg_data[5:0];
          mmt_pkg::REG_B_ROWS: cfg_b_rows = cfg_data[5:0];
          mmt_pkg::REG_DEPTH:  cfg_depth  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        got.func  = func;
        got.row   = row;
        got.col   = col;
        got.value = value;
        compute_dot_beat(got);
        beats_taken++;
      end
    end
  end

  function automatic logic signed [15:0] rand_q88();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly a few hot rows so that long rows are not refilled over and over
  function automatic int pick_row(input int lim, input int hot);
    if ($urandom_range(4) == 0)
      return $urandom_range(lim - 1);
    return $urandom_range(((lim < hot) ? lim : hot) - 1);
  endfunction

  task automatic send_beat(input logic [1:0] f, input int r, input int c,
                           input logic signed [15:0] v);
    mmt_beat_t b;
    b.func  = f;
    b.row   = r[4:0];
    b.col   = c[6:0];
    b.value = v;
    if (f == mmt_pkg::FUNC_QUERY) begin
      useful_beats++;
    end else if (f == mmt_pkg::FUNC_LOAD_A && b.row < gen_ar && b.col < gen_kd) begin
      a_loaded[b.row * mmt_pkg::MAX_DEPTH + b.col] = 1'b1;
      useful_beats++;
    end else if (f == mmt_pkg::FUNC_LOAD_B && b.row < gen_br && b.col < gen_kd) begin
      b_loaded[b.row * mmt_pkg::MAX_DEPTH + b.col] = 1'b1;
      useful_beats++;
    end
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // an in-range query first gets every element it will read written
  task automatic send_query(input int i, input int j);
    if (i < gen_ar && j < gen_br) begin
      for (int k = 0; k < gen_kd; k++) begin
        if (!a_loaded[i * mmt_pkg::MAX_DEPTH + k])
          send_beat(mmt_pkg::FUNC_LOAD_A, i, k, rand_q88());
        if (!b_loaded[j * mmt_pkg::MAX_DEPTH + k])
          send_beat(mmt_pkg::FUNC_LOAD_B, j, k, rand_q88());
      end
    end
    send_beat(mmt_pkg::FUNC_QUERY, i, j, rand_q88());
  endtask

  task automatic wait_drained();
    while (beats_taken != beats_queued || expected_products.size() != 0)
      @(negedge clk);
    // trailing loads raise no strobe, give them time to land
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] ar_w, input logic [7:0] br_w,
                            input logic [7:0] kd_w, input int unsigned pct);
    wait_drained();
    write_reg(mmt_pkg::REG_A_ROWS, ar_w);
    write_reg(mmt_pkg::REG_B_ROWS, br_w);
    write_reg(mmt_pkg::REG_DEPTH, kd_w);
    gen_ar = clamp_to_max(int'(ar_w[5:0]), mmt_pkg::MAX_ROWS);
    gen_br = clamp_to_max(int'(br_w[5:0]), mmt_pkg::MAX_ROWS);
    gen_kd = clamp_to_max(int'(kd_w), mmt_pkg::MAX_DEPTH);
    idle_pct = pct;
    n_settings++;
  endtask

  task automatic run_phase(input logic [7:0] ar_w, input logic [7:0] br_w,
                           input logic [7:0] kd_w, input int n, input int unsigned pct);
    int          hot, pick, i, j, lim;
    int unsigned target;
    logic [1:0]  f;
    set_config(ar_w, br_w, kd_w, pct);
    hot    = (gen_kd > 32) ? 2 : 4;
    target = useful_beats + n;
    while (useful_beats < target) begin
      pick = $urandom_range(99);
      f    = $urandom_range(1) ? mmt_pkg::FUNC_LOAD_B : mmt_pkg::FUNC_LOAD_A;
      lim  = (f == mmt_pkg::FUNC_LOAD_A) ? gen_ar : gen_br;
      if (pick < 40) begin
        if (gen_ar == 0 || gen_br == 0)
          send_query($urandom_range(31), $urandom_range(127));
        else
          send_query(pick_row(gen_ar, hot), pick_row(gen_br, hot));
      end else if (pick < 75) begin
        if (lim > 0 && gen_kd > 0)
          send_beat(f, pick_row(lim, hot), $urandom_range(gen_kd - 1), rand_q88());
        else
          send_beat(f, $urandom_range(31), $urandom_range(127), rand_q88());
      end else begin
        case (pick % 3)
          0: send_beat(f, $urandom_range(31), $urandom_range(127), rand_q88());
          1: begin
            i = $urandom_range(31);
            j = $urandom_range(127);
            if (i < gen_ar && j < gen_br && gen_kd > 32) begin
              i = i % hot;
              j = j % hot;
            end
            send_query(i, j);
          end
          default: send_beat(FUNC_UNUSED, $urandom_range(31), $urandom_range(127), rand_q88());
        endcase
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: extreme operands, corner rows, dropped loads, unused func
    set_config(8'd32, 8'd32, 8'd2, 28);
    send_beat(mmt_pkg::FUNC_LOAD_A, 0, 0, 16'sh8000);
    send_beat(mmt_pkg::FUNC_LOAD_A, 0, 1, 16'sh8000);
    send_beat(mmt_pkg::FUNC_LOAD_B, 0, 0, 16'sh8000);
    send_beat(mmt_pkg::FUNC_LOAD_B, 0, 1, 16'sh8000);
    send_beat(mmt_pkg::FUNC_LOAD_A, 31, 0, 16'sh7FFF);
    send_beat(mmt_pkg::FUNC_LOAD_A, 31, 1, 16'sh8000);
    send_beat(mmt_pkg::FUNC_LOAD_B, 31, 0, 16'sh7FFF);
    send_beat(mmt_pkg::FUNC_LOAD_B, 31, 1, 16'sh7FFF);
    send_query(0, 0);
    send_query(31, 31);
    send_query(31, 0);
    send_query(0, 31);
    send_beat(mmt_pkg::FUNC_LOAD_A, 5, 127, 16'sh1234);
    send_beat(mmt_pkg::FUNC_LOAD_B, 5, 2, 16'sh4321);
    send_beat(FUNC_UNUSED, 31, 127, 16'shFFFF);

    // one row each: out-of-range queries, write to the unused index
    set_config(8'd1, 8'd1, 8'd2, 28);
    write_reg(REG_UNUSED, 8'hFF);
    send_query(1, 0);
    send_query(0, 1);
    send_query(0, 0);
    send_beat(mmt_pkg::FUNC_LOAD_A, 1, 0, 16'sh0100);

    run_phase(8'd32, 8'd32, 8'd8, 250, 28);
    run_phase(8'd0, 8'd5, 8'd8, 60, 28);
    run_phase(8'd7, 8'd3, 8'd1, 150, 28);

    // register values above their limits clamp to the maximum
    run_phase(8'hFF, 8'd33, 8'hFF, 100, 57);
    run_phase(8'd20, 8'd32, 8'd0, 60, 57);
    run_phase(8'd32, 8'd32, 8'd16, 250, 57);

    run_phase(8'd32, 8'd1, 8'd4, 200, 0);
    run_phase(8'd16, 8'd32, 8'd100, 120, 0);
    run_phase(8'd32, 8'd32, 8'd128, 120, 0);
    run_phase(8'd2, 8'd31, 8'd3, 150, 0);

    wait_drained();
    $display("covered %0d loads, %0d queries (%0d out of range), %0d beats dropped",
             n_loads, n_queries, n_query_errs, n_dropped);
    $display("across %0d register settings, sender idle at 28, 57 and 0 percent",
             n_settings);
    if (fails == 0 && expected_products.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #1_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
